>>> hdl/crga_pkg.sv
// shared types, constants and helpers for the color region adjacency block
`default_nettype none
package crga_pkg;

  localparam int MAX_REGIONS = 256;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;

  localparam int ID_W    = $clog2(MAX_REGIONS);
  localparam int LABEL_W = ID_W + 1;
  localparam int COLOR_W = 24;
  localparam int SIZE_W  = 11;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);

  // lookup priority encoder is split into groups
  localparam int GRP    = 16;
  localparam int GRP_W  = $clog2(GRP);
  localparam int NGRP   = MAX_REGIONS / GRP;
  localparam int NGRP_W = $clog2(NGRP);

  localparam int MQ_DEPTH = 16;
  localparam int MQ_AW    = $clog2(MQ_DEPTH);
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  localparam logic KIND_TABLE = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic [0:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [COLOR_W-1:0] pixel_color;
    logic [ID_W-1:0]    region_id;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] region_low;
    logic [ID_W-1:0] region_high;
    logic            last_pair;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0] lo;
    logic [ID_W-1:0] hi;
  } pair_t;

  // everything one pixel asks of the back end
  typedef struct packed {
    logic  clr_before;
    logic  a_vld;
    pair_t a;
    logic  b_vld;
    pair_t b;
    logic  clr_after;
  } pix_rec_t;

  typedef struct packed {
    logic     vld;
    pix_rec_t rec;
  } rec_push_t;

  typedef struct packed {
    logic  two;
    pair_t p0;
    pair_t p1;
  } out_rec_t;

  typedef enum logic [1:0] {
    OP_CLR_BEFORE,
    OP_PAIR_A,
    OP_PAIR_B,
    OP_CLR_AFTER
  } op_t;

  // unordered pair of two nonzero labels, as ids
  function automatic pair_t make_pair(logic [LABEL_W-1:0] a, logic [LABEL_W-1:0] b);
    logic [LABEL_W-1:0] lo;
    logic [LABEL_W-1:0] hi;
    pair_t p;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    lo = lo - LABEL_W'(1);
    hi = hi - LABEL_W'(1);
    p.lo = lo[ID_W-1:0];
    p.hi = hi[ID_W-1:0];
    return p;
  endfunction

endpackage
`default_nettype wire

>>> hdl/color_region_adjacency.sv
// top level of the color region adjacency block: config registers and queue ports
`default_nettype none
// Region adjacency finder. Load the color table first with table items (kind 0:
// pixel_color, region_id), then stream the image in raster order as pixel items
// (kind 1). For every pixel whose region first touches a different region on its
// left or upper side within the current image, a transaction carrying the
// unordered id pair appears on the out side; last_pair marks the final pair of a
// pixel. image_width/image_height are clamped to 1..1024 and should only be
// written while the block is idle. Input takes one item per cycle while in_full
// is low; the front pipeline (table compare, two-level priority encode, line
// store read) never stalls internally. The back end checks one neighbor pair
// per cycle when the result queue has room, against a 256 x 256 bit adjacency
// bitmap (one row per lower id, with per-row valid flops so an image end clears
// it at once), so a pixel with two distinct new-neighbor candidates holds the
// back end for both checks and a pixel at a size wrap also for its clears; runs
// of such pixels are absorbed by a 16-entry record queue before in_full rises.
// There is no clearing pass after reset.
module color_region_adjacency import crga_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire in_item_t          in_item,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output out_item_t              out_item,
  input  wire logic              cfg_wr_en,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [SIZE_W-1:0] cfg_wdata
);

  logic [SIZE_W-1:0] width_r, height_r;
  logic              in_acc;
  rec_push_t         rec_push;
  logic [2:0]        inflight;
  logic [MQ_AW:0]    mq_count;
  logic [MQ_AW+1:0]  load;

  // config registers, to be written only when idle; the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(MAX_WIDTH);
      height_r <= SIZE_W'(MAX_HEIGHT);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
      endcase
    end
  end

  // credit: queued records plus items still in the front pipeline
  always_comb begin
    load    = (MQ_AW+2)'(mq_count) + (MQ_AW+2)'(inflight);
    in_full = (load >= (MQ_AW+2)'(MQ_DEPTH));
    in_acc  = in_push && !in_full;
  end

  crga_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .in_item    (in_item),
    .img_width  (width_r),
    .img_height (height_r),
    .rec_push   (rec_push),
    .inflight   (inflight)
  );

  crga_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_push  (rec_push),
    .mq_count  (mq_count),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

>>> hdl/crga_front.sv
// front end: color lookup pipeline, raster counters, line store and pair candidates
`default_nettype none
module crga_front import crga_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_acc,
  input  wire in_item_t          in_item,
  input  wire logic [SIZE_W-1:0] img_width,
  input  wire logic [SIZE_W-1:0] img_height,
  output rec_push_t              rec_push,
  output logic [2:0]             inflight
);

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             row_nz;
    logic             cb;
    logic             ca;
  } pix_meta_t;

  logic                   s0_v_r;
  in_item_t               s0_item_r;
  logic [COLOR_W-1:0]     tbl_color_r [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] tbl_vld_r;
  logic [COL_W-1:0]       col_r;
  logic [ROW_W-1:0]       row_r;

  logic [SIZE_W-1:0] w_eff, h_eff, col_a, row_a, col_p, row_p;
  logic              cb, ca, s0_pix;
  logic [MAX_REGIONS-1:0] match;

  logic                   s1_v_r;
  logic [MAX_REGIONS-1:0] s1_match_r;
  pix_meta_t              s1_meta_r;

  logic             s2_v_r;
  logic [NGRP-1:0]  s2_any_r;
  logic [GRP_W-1:0] s2_idx_r [NGRP];
  pix_meta_t        s2_meta_r;
  logic [GRP_W-1:0] grp_idx [NGRP];
  logic [NGRP-1:0]  grp_any;

  logic [LABEL_W-1:0] label_nxt;

  logic               s3_v_r;
  logic [LABEL_W-1:0] s3_label_r;
  logic [LABEL_W-1:0] s3_up_mem_r;
  pix_meta_t          s3_meta_r;
  logic [LABEL_W-1:0] line_mem [MAX_WIDTH];

  logic               fwd_v_r;
  logic [COL_W-1:0]   fwd_col_r;
  logic [LABEL_W-1:0] fwd_label_r;
  logic [LABEL_W-1:0] left_r;
  logic [LABEL_W-1:0] up;
  pair_t              pa, pb;
  logic               a_ok, b_ok;

  // stage 0: clamp sizes, step raster counters, compare against table
  always_comb begin
    w_eff = img_width;
    h_eff = img_height;
    if (img_width == '0) w_eff = SIZE_W'(1);
    else if (img_width > SIZE_W'(MAX_WIDTH)) w_eff = SIZE_W'(MAX_WIDTH);
    if (img_height == '0) h_eff = SIZE_W'(1);
    else if (img_height > SIZE_W'(MAX_HEIGHT)) h_eff = SIZE_W'(MAX_HEIGHT);

    col_a = SIZE_W'(col_r);
    row_a = SIZE_W'(row_r);
    cb    = 1'b0;
    if (col_a >= w_eff) begin
      col_a = '0;
      row_a = row_a + SIZE_W'(1);
    end
    if (row_a >= h_eff) begin
      row_a = '0;
      cb    = 1'b1;
    end
    col_p = col_a + SIZE_W'(1);
    row_p = row_a;
    ca    = 1'b0;
    if (col_p >= w_eff) begin
      col_p = '0;
      row_p = row_a + SIZE_W'(1);
      if (row_p >= h_eff) begin
        row_p = '0;
        ca    = 1'b1;
      end
    end
    s0_pix = s0_v_r && (s0_item_r.kind == KIND_PIXEL);
    for (int i = 0; i < MAX_REGIONS; i++) begin
      match[i] = tbl_vld_r[i] && (tbl_color_r[i] == s0_item_r.pixel_color);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r    <= 1'b0;
      tbl_vld_r <= '0;
      col_r     <= '0;
      row_r     <= '0;
    end else begin
      s0_v_r <= in_acc;
      if (s0_v_r && s0_item_r.kind == KIND_TABLE) begin
        tbl_vld_r[s0_item_r.region_id] <= 1'b1;
      end
      if (s0_pix) begin
        col_r <= col_p[COL_W-1:0];
        row_r <= row_p[ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s0_item_r <= in_item;
    if (s0_v_r && s0_item_r.kind == KIND_TABLE) begin
      tbl_color_r[s0_item_r.region_id] <= s0_item_r.pixel_color;
    end
    s1_match_r       <= match;
    s1_meta_r.col    <= col_a[COL_W-1:0];
    s1_meta_r.row_nz <= (row_a != '0);
    s1_meta_r.cb     <= cb;
    s1_meta_r.ca     <= ca;
  end

  // stage 1: lowest match inside each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_idx[g] = '0;
      grp_any[g] = 1'b0;
      for (int j = GRP - 1; j >= 0; j--) begin
        if (s1_match_r[g*GRP + j]) begin
          grp_idx[g] = GRP_W'(j);
          grp_any[g] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_any_r  <= grp_any;
    s2_idx_r  <= grp_idx;
    s2_meta_r <= s1_meta_r;
  end

  // stage 2: lowest group gives the label, line store read
  always_comb begin
    label_nxt = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (s2_any_r[g]) label_nxt = {1'b0, NGRP_W'(g), s2_idx_r[g]} + LABEL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    s3_label_r  <= label_nxt;
    s3_meta_r   <= s2_meta_r;
    s3_up_mem_r <= line_mem[s2_meta_r.col];
    if (s3_v_r) line_mem[s3_meta_r.col] <= s3_label_r;
  end

  // stage 3: neighbor compare, line store write
  always_comb begin
    up = (fwd_v_r && fwd_col_r == s3_meta_r.col) ? fwd_label_r : s3_up_mem_r;
    pa = make_pair(s3_label_r, left_r);
    pb = make_pair(s3_label_r, up);
    a_ok = (s3_meta_r.col != '0) && (s3_label_r != '0) && (left_r != '0)
           && (s3_label_r != left_r);
    b_ok = s3_meta_r.row_nz && (s3_label_r != '0) && (up != '0) && (s3_label_r != up)
           && !(a_ok && pa == pb);
    rec_push.vld           = s3_v_r && (a_ok || b_ok || s3_meta_r.cb || s3_meta_r.ca);
    rec_push.rec.clr_before = s3_meta_r.cb;
    rec_push.rec.a_vld      = a_ok;
    rec_push.rec.a          = pa;
    rec_push.rec.b_vld      = b_ok;
    rec_push.rec.b          = pb;
    rec_push.rec.clr_after  = s3_meta_r.ca;
    inflight = 3'(s0_v_r) + 3'(s1_v_r) + 3'(s2_v_r) + 3'(s3_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
      left_r  <= '0;
    end else begin
      s1_v_r  <= s0_pix;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      fwd_v_r <= s3_v_r;
      if (s3_v_r) left_r <= s3_label_r;
    end
  end

  always_ff @(posedge clk) begin
    fwd_col_r   <= s3_meta_r.col;
    fwd_label_r <= s3_label_r;
  end

endmodule
`default_nettype wire

>>> hdl/crga_back.sv
// back end: pixel record queue, adjacency bitmap check and result queue
`default_nettype none
module crga_back import crga_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire rec_push_t  rec_push,
  output logic [MQ_AW:0]  mq_count,
  input  wire logic       out_pop,
  output logic            out_empty,
  output out_item_t       out_item
);

  pix_rec_t         mq_r [MQ_DEPTH];
  logic [MQ_AW-1:0] mq_wp_r, mq_rp_r;
  logic [MQ_AW:0]   mq_cnt_r;

  out_rec_t         oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wp_r, oq_rp_r;
  logic [OQ_AW:0]   oq_cnt_r;
  logic             sub_r;

  op_t      step_r;
  op_t      sel;
  pix_rec_t head;
  logic     more, issue, pop_rec, iss_end;
  pair_t    iss_pair;
  logic [OQ_AW+1:0] oq_load;

  logic  op_v_r, op_end_r;
  op_t   op_kind_r;
  pair_t op_pair_r;

  logic [MAX_REGIONS-1:0] seen_mem [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] rdata_r;
  logic [MAX_REGIONS-1:0] row_vld_r;
  logic                   wr_v_r;
  logic [ID_W-1:0]        wr_lo_r;
  logic [MAX_REGIONS-1:0] wr_word_r;
  logic [MAX_REGIONS-1:0] base, new_word;
  logic                   is_pair, is_clr, fresh, oq_push, oq_pop, out_last;
  out_rec_t               oq_in, oq_head;

  logic  h_v_r;
  pair_t h_pair_r;

  // issue one operation of the head record per cycle while a record is queued and the result queue has room
  always_comb begin
    head    = mq_r[mq_rp_r];
    oq_load = (OQ_AW+2)'(oq_cnt_r) + (OQ_AW+2)'(op_v_r);
    priority if (head.clr_before && step_r == OP_CLR_BEFORE) sel = OP_CLR_BEFORE;
    else if (head.a_vld && step_r <= OP_PAIR_A) sel = OP_PAIR_A;
    else if (head.b_vld && step_r <= OP_PAIR_B) sel = OP_PAIR_B;
    else sel = OP_CLR_AFTER;
    unique case (sel)
      OP_CLR_BEFORE: more = head.a_vld || head.b_vld || head.clr_after;
      OP_PAIR_A:     more = head.b_vld || head.clr_after;
      OP_PAIR_B:     more = head.clr_after;
      OP_CLR_AFTER:  more = 1'b0;
    endcase
    issue    = (mq_cnt_r != '0) && (oq_load < (OQ_AW+2)'(OQ_DEPTH));
    pop_rec  = issue && !more;
    iss_pair = (sel == OP_PAIR_A) ? head.a : head.b;
    iss_end  = (sel == OP_PAIR_B) || (sel == OP_PAIR_A && !head.b_vld);
    mq_count = mq_cnt_r;
  end

  // bitmap check; the previous cycle's write is forwarded
  always_comb begin
    is_pair = op_v_r && (op_kind_r == OP_PAIR_A || op_kind_r == OP_PAIR_B);
    is_clr  = op_v_r && (op_kind_r == OP_CLR_BEFORE || op_kind_r == OP_CLR_AFTER);
    if (wr_v_r && wr_lo_r == op_pair_r.lo) base = wr_word_r;
    else if (row_vld_r[op_pair_r.lo]) base = rdata_r;
    else base = '0;
    fresh    = is_pair && !base[op_pair_r.hi];
    new_word = base | (MAX_REGIONS'(1) << op_pair_r.hi);
    oq_push  = is_pair && op_end_r && (h_v_r || fresh);
    oq_in.two = h_v_r && fresh;
    oq_in.p0  = h_v_r ? h_pair_r : op_pair_r;
    oq_in.p1  = op_pair_r;
  end

  always_ff @(posedge clk) begin
    if (rec_push.vld) mq_r[mq_wp_r] <= rec_push.rec;
    rdata_r <= seen_mem[iss_pair.lo];
    if (fresh) seen_mem[op_pair_r.lo] <= new_word;
    op_kind_r <= sel;
    op_pair_r <= iss_pair;
    op_end_r  <= iss_end;
    wr_lo_r   <= op_pair_r.lo;
    wr_word_r <= new_word;
    if (oq_push) oq_r[oq_wp_r] <= oq_in;
    if (is_pair && !op_end_r) h_pair_r <= op_pair_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mq_wp_r   <= '0;
      mq_rp_r   <= '0;
      mq_cnt_r  <= '0;
      step_r    <= OP_CLR_BEFORE;
      op_v_r    <= 1'b0;
      wr_v_r    <= 1'b0;
      row_vld_r <= '0;
      h_v_r     <= 1'b0;
      oq_wp_r   <= '0;
      oq_rp_r   <= '0;
      oq_cnt_r  <= '0;
      sub_r     <= 1'b0;
    end else begin
      if (rec_push.vld) mq_wp_r <= mq_wp_r + MQ_AW'(1);
      if (pop_rec) mq_rp_r <= mq_rp_r + MQ_AW'(1);
      mq_cnt_r <= mq_cnt_r + (MQ_AW+1)'(rec_push.vld) - (MQ_AW+1)'(pop_rec);
      if (issue) step_r <= more ? op_t'(sel + 2'd1) : OP_CLR_BEFORE;
      op_v_r <= issue;
      wr_v_r <= fresh;
      if (is_clr) row_vld_r <= '0;
      else if (fresh) row_vld_r[op_pair_r.lo] <= 1'b1;
      if (is_pair) h_v_r <= op_end_r ? 1'b0 : fresh;
      if (oq_push) oq_wp_r <= oq_wp_r + OQ_AW'(1);
      if (oq_pop) begin
        if (out_last) begin
          oq_rp_r <= oq_rp_r + OQ_AW'(1);
          sub_r   <= 1'b0;
        end else begin
          sub_r <= 1'b1;
        end
      end
      oq_cnt_r <= oq_cnt_r + (OQ_AW+1)'(oq_push) - (OQ_AW+1)'(oq_pop && out_last);
    end
  end

  // result side: one pair per pop
  always_comb begin
    oq_head   = oq_r[oq_rp_r];
    out_empty = (oq_cnt_r == '0);
    out_last  = !oq_head.two || sub_r;
    oq_pop    = out_pop && !out_empty;
    out_item.region_low  = sub_r ? oq_head.p1.lo : oq_head.p0.lo;
    out_item.region_high = sub_r ? oq_head.p1.hi : oq_head.p0.hi;
    out_item.last_pair   = out_last;
  end

  a_mq_room: assert property (@(posedge clk) disable iff (!rst_n)
    rec_push.vld |-> (mq_cnt_r < (MQ_AW+1)'(MQ_DEPTH)))
    else $error("record queue overflow");

  a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> (oq_cnt_r < (OQ_AW+1)'(OQ_DEPTH)))
    else $error("result queue overflow");

  a_two_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (oq_push && oq_in.two) |-> (oq_in.p0 != oq_in.p1))
    else $error("same pair emitted twice for one pixel");

  a_hold_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    (is_pair && op_end_r) |=> !h_v_r)
    else $error("held pair not flushed at end of pixel");

endmodule
`default_nettype wire
